// ----- design/acem_pkg.sv -----
// Shared types and constants for the alpha choke/expand morphology block.
// Depends on nothing; the interface, top and divider files refer to it by scoped names.
package acem_pkg;

  // Bits per color or alpha channel.
  localparam int CHANNEL_BITS = 16;
  localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;

  // Default frame and radius limits.
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_RADIUS_DEF = 8;

  // Configuration register map.
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int RADIUS_W     = 13;
  localparam int DIM_W        = 7;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [DIM_W-1:0]     DIM_RESET  = 7'd64;

  // Input action codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Divider widths: a product of two channels over one channel.
  localparam int DIV_NW = 2 * CHANNEL_BITS;
  localparam int DIV_DW = CHANNEL_BITS;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  // One stored pixel.
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] alpha;
  } pixel_t;

endpackage

// ----- design/acem_if.sv -----
// Valid/ready channel interfaces for the input and result words.
// Depends on acem_pkg for the channel width.
interface acem_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [acem_pkg::CHANNEL_BITS-1:0] red_in;
  logic [acem_pkg::CHANNEL_BITS-1:0] green_in;
  logic [acem_pkg::CHANNEL_BITS-1:0] blue_in;
  logic [acem_pkg::CHANNEL_BITS-1:0] alpha_in;

  modport source (output valid, action, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface acem_out_if;
  logic                             valid;
  logic                             ready;
  logic [acem_pkg::CHANNEL_BITS-1:0] red_out;
  logic [acem_pkg::CHANNEL_BITS-1:0] green_out;
  logic [acem_pkg::CHANNEL_BITS-1:0] blue_out;
  logic [acem_pkg::CHANNEL_BITS-1:0] alpha_out;
  logic                             last_pixel;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, last_pixel,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_pixel,
                  output ready);
endinterface

// ----- design/alpha_choke_expand_morphology.sv -----
// Top level of the alpha choke/expand block: frame memory, neighbor scan, blend.
// Depends on acem_pkg, acem_if, acem_ram and acem_div.
//
// Use: write choke_radius, frame_width and frame_height on the cfg_ port while
// the block is idle. Then send a frame in raster order on in_ch with action
// at load, one pixel per word; each load gives no result.
// Each word with action at read yields one pixel on out_ch, in raster order,
// with last_pixel set on the final pixel of the frame.
// A read first fetches the pixel and splits its position into column and
// row in the divider. With a radius magnitude above 2/256 it then scans
// the (2r+1)^2 window, one frame memory read a cycle, blends the alpha and
// rescales the three colors through the same divider when alpha is nonzero.
// Otherwise the stored pixel passes through unchanged. One word is worked
// on at a time. A finished result sits in the output register while the
// next word is accepted; a stalled receiver holds the block only once the
// next result is ready. Reset clears the state, the load and read positions
// and the output valid flag and sets the configuration registers to their
// defaults (radius 0, 64 by 64 frame); the frame memory holds garbage until
// loaded.
module alpha_choke_expand_morphology #(
  parameter int MAX_WIDTH  = acem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = acem_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = acem_pkg::MAX_RADIUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [acem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acem_pkg::CFG_DATA_W-1:0]   cfg_data,
  acem_in_if.sink                           in_ch,
  acem_out_if.source                        out_ch
);

  localparam int CB     = acem_pkg::CHANNEL_BITS;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW     = $clog2(DEPTH + 1);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int SW     = ((RW > acem_pkg::DIM_W) ? RW : acem_pkg::DIM_W) + 2;
  localparam int SQW    = 2 * RW + 1;
  localparam int MAGW   = 14;
  localparam int MAGMAX = MAX_RADIUS * 256;
  localparam int DIMW   = acem_pkg::DIM_W;
  localparam int NW     = acem_pkg::DIV_NW;
  localparam int DW     = acem_pkg::DIV_DW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CENTER, ST_LOCATE, ST_SCAN, ST_DRAIN,
    ST_BLEND, ST_MUL, ST_CDIV, ST_CWAIT, ST_OUT
  } state_t;

  // Configuration registers.
  logic [acem_pkg::RADIUS_W-1:0] radius_r;
  logic [DIMW-1:0]               width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      width_r  <= acem_pkg::DIM_RESET;
      height_r <= acem_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acem_pkg::REG_RADIUS: radius_r <= cfg_data[acem_pkg::RADIUS_W-1:0];
        acem_pkg::REG_WIDTH:  width_r  <= cfg_data[DIMW-1:0];
        acem_pkg::REG_HEIGHT: height_r <= cfg_data[DIMW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame size and pixel count.
  logic [DIMW-1:0]   wc, hc;
  logic [2*DIMW-1:0] count_w;

  always_comb begin
    wc = width_r;
    if (width_r == '0) wc = DIMW'(1);
    else if (32'(width_r) > MAX_WIDTH) wc = DIMW'(MAX_WIDTH);
    hc = height_r;
    if (height_r == '0) hc = DIMW'(1);
    else if (32'(height_r) > MAX_HEIGHT) hc = DIMW'(MAX_HEIGHT);
    count_w = wc * hc;
  end

  // Radius magnitude, disc radius and fraction.
  logic            negative;
  logic [MAGW-1:0] mag_raw, mag_c;
  logic [MAGW-1:0] mag_up;
  logic [RW-1:0]   r_now;

  always_comb begin
    negative = radius_r[acem_pkg::RADIUS_W-1];
    mag_raw  = negative ? MAGW'(14'h2000 - {1'b0, radius_r}) : MAGW'(radius_r);
    mag_c    = (32'(mag_raw) > MAGMAX) ? MAGW'(MAGMAX) : mag_raw;
    mag_up   = mag_c + MAGW'(255);
    r_now    = RW'(mag_up[MAGW-1:8]);
  end

  // Positions.
  logic [PW-1:0] load_pos_r, load_pos_nxt;
  logic [PW-1:0] read_pos_r, read_pos_nxt;
  logic [PW-1:0] lpos, rpos;

  always_comb begin
    lpos = (32'(load_pos_r) < 32'(count_w)) ? load_pos_r : '0;
    rpos = (32'(read_pos_r) < 32'(count_w)) ? read_pos_r : '0;
  end

  // Frame memory.
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  acem_pkg::pixel_t        ram_wdata, ram_rdata;

  acem_ram #(.WIDTH($bits(acem_pkg::pixel_t)), .DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared divider.
  acem_pkg::div_req_t div_req;
  acem_pkg::div_rsp_t div_rsp;

  acem_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Working registers.
  state_t            state_r, state_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  acem_pkg::pixel_t  px_r, px_nxt;
  acem_pkg::pixel_t  res_r, res_nxt;
  logic [DIMW-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [SW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [RW-1:0]     r_r, r_nxt;
  logic [7:0]        frac_r, frac_nxt;
  logic              neg_r, neg_nxt;
  logic              pass_r, pass_nxt;
  logic              pend_r, pend_nxt;
  logic [CB-1:0]     filt_r, filt_nxt;
  logic [CB-1:0]     na_r, na_nxt;
  logic [NW-1:0]     prod_r, prod_nxt;
  logic [1:0]        k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  acem_pkg::pixel_t  out_px_r, out_px_nxt;
  logic              out_last_r, out_last_nxt;

  // Neighbor geometry for the current window offset.
  logic signed [SW-1:0] nx, ny, rs;
  logic [SW-1:0]        adx, ady;
  logic [SQW-1:0]       dist_sq, rr;
  logic                 in_frame, in_disc, cell_ok;
  logic [2*DIMW-1:0]    naddr;

  always_comb begin
    rs       = $signed({{(SW-RW){1'b0}}, r_r});
    nx       = $signed({{(SW-DIMW){1'b0}}, x_r}) + dx_r;
    ny       = $signed({{(SW-DIMW){1'b0}}, y_r}) + dy_r;
    adx      = dx_r[SW-1] ? SW'(-dx_r) : SW'(dx_r);
    ady      = dy_r[SW-1] ? SW'(-dy_r) : SW'(dy_r);
    dist_sq  = SQW'(adx[RW-1:0] * adx[RW-1:0]) + SQW'(ady[RW-1:0] * ady[RW-1:0]);
    rr       = SQW'(r_r * r_r);
    in_frame = !nx[SW-1] && !ny[SW-1]
            && (nx < $signed({{(SW-DIMW){1'b0}}, wc}))
            && (ny < $signed({{(SW-DIMW){1'b0}}, hc}));
    in_disc  = dist_sq <= rr;
    cell_ok  = in_frame && in_disc;
    naddr    = (2*DIMW)'(ny[DIMW-1:0] * wc) + (2*DIMW)'(nx[DIMW-1:0]);
  end

  // Alpha fold of the word read in the previous cycle.
  logic [CB-1:0] folded;

  always_comb begin
    folded = filt_r;
    if (pend_r) begin
      if (neg_r) begin
        if (ram_rdata.alpha > filt_r) folded = ram_rdata.alpha;
      end else begin
        if (ram_rdata.alpha < filt_r) folded = ram_rdata.alpha;
      end
    end
  end

  // Alpha blend and color rounding.
  logic [CB+9:0]   blend_sum;
  logic [CB+10:0]  blend_rnd;
  logic [NW:0]     q_rnd;
  logic [CB-1:0]   q_sat;
  logic [CB-1:0]   col_k;

  always_comb begin
    blend_sum = (CB+10)'(px_r.alpha * frac_r)
              + (CB+10)'(filt_r * (10'd512 - {2'b00, frac_r}));
    blend_rnd = (CB+11)'(blend_sum) + (CB+11)'(256);
    q_rnd     = (NW+1)'(div_rsp.quot)
              + (NW+1)'(({1'b0, div_rsp.rem, 1'b0} >= {2'b00, px_r.alpha}) ? 1 : 0);
    q_sat     = (q_rnd > (NW+1)'(acem_pkg::CHAN_MAX)) ? CB'(acem_pkg::CHAN_MAX)
                                                      : q_rnd[CB-1:0];
    case (k_r)
      2'd0:    col_k = px_r.red;
      2'd1:    col_k = px_r.green;
      default: col_k = px_r.blue;
    endcase
  end

  // Sequencer.
  logic in_fire, out_free;

  always_comb begin
    in_fire   = in_ch.valid && (state_r == ST_IDLE);
    out_free  = !out_valid_r || out_ch.ready;

    state_nxt    = state_r;
    load_pos_nxt = load_pos_r;
    read_pos_nxt = read_pos_r;
    pos_nxt      = pos_r;
    px_nxt       = px_r;
    res_nxt      = res_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    r_nxt        = r_r;
    frac_nxt     = frac_r;
    neg_nxt      = neg_r;
    pass_nxt     = pass_r;
    pend_nxt     = 1'b0;
    filt_nxt     = filt_r;
    na_nxt       = na_r;
    prod_nxt     = prod_r;
    k_nxt        = k_r;
    out_px_nxt   = out_px_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    ram_we    = 1'b0;
    ram_waddr = AW'(lpos);
    ram_wdata = '{red: in_ch.red_in, green: in_ch.green_in,
                  blue: in_ch.blue_in, alpha: in_ch.alpha_in};
    ram_raddr = AW'(rpos);
    div_req   = '{start: 1'b0, dividend: NW'(pos_r), divisor: DW'(wc)};

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.action == acem_pkg::ACT_LOAD) begin
            ram_we       = 1'b1;
            load_pos_nxt = (32'(lpos) + 1 >= 32'(count_w)) ? '0 : PW'(lpos + 1'b1);
          end else begin
            pos_nxt      = rpos;
            read_pos_nxt = (32'(rpos) + 1 >= 32'(count_w)) ? '0 : PW'(rpos + 1'b1);
            r_nxt        = r_now;
            frac_nxt     = mag_c[7:0];
            neg_nxt      = negative;
            pass_nxt     = mag_c <= MAGW'(2);
            state_nxt    = ST_CENTER;
          end
        end
      end
      ST_CENTER: begin
        px_nxt        = ram_rdata;
        div_req.start = 1'b1;
        state_nxt     = ST_LOCATE;
      end
      ST_LOCATE: begin
        if (div_rsp.done) begin
          x_nxt = DIMW'(div_rsp.rem);
          y_nxt = DIMW'(div_rsp.quot);
          if (pass_r) begin
            res_nxt   = px_r;
            state_nxt = ST_OUT;
          end else begin
            dx_nxt    = -rs;
            dy_nxt    = -rs;
            filt_nxt  = px_r.alpha;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        filt_nxt  = folded;
        ram_raddr = AW'(naddr);
        pend_nxt  = cell_ok;
        if (dx_r == rs) begin
          dx_nxt = -rs;
          dy_nxt = dy_r + SW'(1);
          if (dy_r == rs) state_nxt = ST_DRAIN;
        end else begin
          dx_nxt = dx_r + SW'(1);
        end
      end
      ST_DRAIN: begin
        filt_nxt  = folded;
        state_nxt = ST_BLEND;
      end
      ST_BLEND: begin
        na_nxt = (blend_rnd[CB+10:9] > (CB+2)'(acem_pkg::CHAN_MAX))
               ? CB'(acem_pkg::CHAN_MAX) : blend_rnd[CB+8:9];
        res_nxt = px_r;
        k_nxt   = 2'd0;
        state_nxt = (px_r.alpha == '0) ? ST_OUT : ST_MUL;
      end
      ST_MUL: begin
        res_nxt.alpha = na_r;
        prod_nxt      = NW'(col_k * na_r);
        state_nxt     = ST_CDIV;
      end
      ST_CDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = px_r.alpha;
        state_nxt        = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (div_rsp.done) begin
          case (k_r)
            2'd0:    res_nxt.red   = q_sat;
            2'd1:    res_nxt.green = q_sat;
            default: res_nxt.blue  = q_sat;
          endcase
          if (k_r == 2'd2) begin
            state_nxt = ST_OUT;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_px_nxt    = res_r;
          if (!pass_r) out_px_nxt.alpha = na_r;
          out_last_nxt  = 32'(pos_r) + 1 >= 32'(count_w);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_pos_r  <= '0;
      read_pos_r  <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_pos_r  <= load_pos_nxt;
      read_pos_r  <= read_pos_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
    pos_r      <= pos_nxt;
    px_r       <= px_nxt;
    res_r      <= res_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    r_r        <= r_nxt;
    frac_r     <= frac_nxt;
    neg_r      <= neg_nxt;
    pass_r     <= pass_nxt;
    filt_r     <= filt_nxt;
    na_r       <= na_nxt;
    prod_r     <= prod_nxt;
    k_r        <= k_nxt;
    out_px_r   <= out_px_nxt;
    out_last_r <= out_last_nxt;
  end

  // Channel ports.
  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.red_out    = out_px_r.red;
  assign out_ch.green_out  = out_px_r.green;
  assign out_ch.blue_out   = out_px_r.blue;
  assign out_ch.alpha_out  = out_px_r.alpha;
  assign out_ch.last_pixel = out_last_r;

endmodule

// ----- design/acem_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module acem_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/acem_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on acem_pkg for the request and answer types.
module acem_div (
  input  logic               clk,
  input  logic               rst_n,
  input  acem_pkg::div_req_t req,
  output acem_pkg::div_rsp_t rsp
);

  localparam int NW = acem_pkg::DIV_NW;
  localparam int DW = acem_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  // One shift-and-subtract step per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[NW-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DW'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- test/alpha_choke_expand_morphology_test.sv -----
`timescale 1ns / 100ps
// Testbench for the alpha choke/expand morphology block: directed and random frames,
// checked word by word against a disc erosion/dilation predictor. Depends on acem_pkg
// and the acem_in_if / acem_out_if channel interfaces.
module alpha_choke_expand_morphology_test;

  localparam int STORE_DEPTH = acem_pkg::MAX_WIDTH_DEF * acem_pkg::MAX_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int IDLE_WAIT = 60;
  localparam int WORD_TARGET = 1200;
  localparam int CB = acem_pkg::CHANNEL_BITS;
  localparam int RADW = acem_pkg::RADIUS_W;
  localparam int DIMW = acem_pkg::DIM_W;

  // One expected output word.
  typedef struct {
    acem_pkg::pixel_t px;
    logic             last;
  } out_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [acem_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [acem_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  acem_in_if in_ch ();
  acem_out_if out_ch ();

  alpha_choke_expand_morphology u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Predictor state: a copy of the frame memory, positions and registers.
  acem_pkg::pixel_t pix_store [STORE_DEPTH];
  int load_pos;
  int read_pos;
  logic [RADW-1:0] radius_reg;
  logic [DIMW-1:0] width_reg;
  logic [DIMW-1:0] height_reg;
  out_word_t pending_words [$];

  int mismatches = 0;
  int words_sent = 0;
  int cycles = 0;
  int stall_left = 0;
  int hold_req = 0;
  int hold_left = 0;
  bit quiet = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cycle counter with a hard timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int dim_clamp(int v);
    if (v < 1) return 1;
    if (v > acem_pkg::MAX_WIDTH_DEF) return acem_pkg::MAX_WIDTH_DEF;
    return v;
  endfunction

  // Rounded color rescale by new/orig, saturated to the channel maximum.
  function automatic logic [CB-1:0] rescale(longint c, longint na, longint orig);
    longint p;
    longint q;
    p = c * na;
    q = p / orig;
    if (2 * (p % orig) >= orig) q++;
    if (q > acem_pkg::CHAN_MAX) q = acem_pkg::CHAN_MAX;
    return q[CB-1:0];
  endfunction

  // Applies one accepted word to the predictor; a read queues its expected pixel.
  task automatic predict_word(input logic act, input acem_pkg::pixel_t px);
    int w, h, cnt, pos, mag, r, frac, x, y, nx, ny;
    bit neg;
    longint orig, filt, v, na;
    out_word_t e;
    w = dim_clamp(width_reg);
    h = dim_clamp(height_reg);
    cnt = w * h;
    if (act == acem_pkg::ACT_LOAD) begin
      pos = (load_pos < cnt) ? load_pos : 0;
      pix_store[pos] = px;
      load_pos = (pos + 1 >= cnt) ? 0 : pos + 1;
    end else begin
      pos = (read_pos < cnt) ? read_pos : 0;
      e.px = pix_store[pos];
      neg = radius_reg[RADW-1];
      mag = neg ? ((14'h2000 - radius_reg) & 13'h1FFF) : radius_reg;
      if (neg && mag == 0) mag = 4096;
      if (mag > acem_pkg::MAX_RADIUS_DEF * 256) mag = acem_pkg::MAX_RADIUS_DEF * 256;
      if (mag > 2) begin
        r = (mag + 255) >> 8;
        frac = mag & 255;
        x = pos % w;
        y = pos / w;
        orig = pix_store[pos].alpha;
        filt = orig;
        for (int dy = -r; dy <= r; dy++) begin
          ny = y + dy;
          if (ny < 0 || ny >= h) continue;
          for (int dx = -r; dx <= r; dx++) begin
            nx = x + dx;
            if (nx < 0 || nx >= w || dx * dx + dy * dy > r * r) continue;
            v = pix_store[ny * w + nx].alpha;
            if (!neg && v < filt) filt = v;
            if (neg && v > filt) filt = v;
          end
        end
        na = (orig * frac + filt * (512 - frac) + 256) >> 9;
        if (na > acem_pkg::CHAN_MAX) na = acem_pkg::CHAN_MAX;
        e.px.alpha = na[CB-1:0];
        if (orig > 0) begin
          e.px.red = rescale(pix_store[pos].red, na, orig);
          e.px.green = rescale(pix_store[pos].green, na, orig);
          e.px.blue = rescale(pix_store[pos].blue, na, orig);
        end
      end
      e.last = (pos + 1 >= cnt);
      read_pos = (pos + 1 >= cnt) ? 0 : pos + 1;
      pending_words.push_back(e);
    end
  endtask

  // Sends one word after a random gap and waits for it to be accepted.
  task automatic send_word(input logic act, input acem_pkg::pixel_t px);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.action = act;
    in_ch.red_in = px.red;
    in_ch.green_in = px.green;
    in_ch.blue_in = px.blue;
    in_ch.alpha_in = px.alpha;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(act, px);
    words_sent++;
  endtask

  // Waits for all results, lets the block settle, then writes one register.
  task automatic write_reg(input logic [acem_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[acem_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      acem_pkg::REG_RADIUS: radius_reg = value[RADW-1:0];
      acem_pkg::REG_WIDTH: width_reg = value[DIMW-1:0];
      default: height_reg = value[DIMW-1:0];
    endcase
  endtask

  // Random pixel: mostly premultiplied, sometimes extreme or unconstrained.
  function automatic acem_pkg::pixel_t rand_pixel();
    acem_pkg::pixel_t p;
    case ($urandom_range(0, 5))
      0: p.alpha = 16'h0000;
      1: p.alpha = 16'hFFFF;
      default: p.alpha = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 4) == 0) begin
      p.red = $urandom_range(0, 65535);
      p.green = $urandom_range(0, 65535);
      p.blue = $urandom_range(0, 65535);
    end else begin
      p.red = $urandom_range(0, p.alpha);
      p.green = $urandom_range(0, p.alpha);
      p.blue = $urandom_range(0, p.alpha);
    end
    return p;
  endfunction

  // Loads every pixel of the current frame so later reads see written data.
  task automatic load_frame();
    int cnt;
    cnt = dim_clamp(width_reg) * dim_clamp(height_reg);
    repeat (cnt) send_word(acem_pkg::ACT_LOAD, rand_pixel());
  endtask

  // Extreme pixels on a 3x3 frame under erode, dilate, tiny and saturated radii.
  task automatic test_directed();
    acem_pkg::pixel_t p;
    acem_pkg::pixel_t corner [9];
    corner[0] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    corner[1] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    corner[2] = '{16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001};
    corner[3] = '{16'h5555, 16'hAAAA, 16'h0000, 16'h8000};
    corner[4] = '{16'h4000, 16'h2000, 16'h1000, 16'h8001};
    corner[5] = '{16'hFFFF, 16'h0000, 16'h1234, 16'h0000};
    corner[6] = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    corner[7] = '{16'h0003, 16'h0002, 16'h0001, 16'h0004};
    corner[8] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE};
    write_reg(acem_pkg::REG_WIDTH, 3);
    write_reg(acem_pkg::REG_HEIGHT, 3);
    write_reg(acem_pkg::REG_RADIUS, 384);
    for (int i = 0; i < 9; i++) send_word(acem_pkg::ACT_LOAD, corner[i]);
    p = '0;
    repeat (9) send_word(acem_pkg::ACT_READ, p);
    write_reg(acem_pkg::REG_RADIUS, 13'h1000);
    repeat (3) send_word(acem_pkg::ACT_READ, p);
    write_reg(acem_pkg::REG_RADIUS, 2);
    repeat (2) send_word(acem_pkg::ACT_READ, p);
    write_reg(acem_pkg::REG_RADIUS, 3);
    send_word(acem_pkg::ACT_READ, p);
  endtask

  // The receiver holds off while reads keep coming, so the input stalls.
  task automatic test_backpressure();
    write_reg(acem_pkg::REG_WIDTH, 4);
    write_reg(acem_pkg::REG_HEIGHT, 4);
    write_reg(acem_pkg::REG_RADIUS, -13'sd256);
    load_frame();
    hold_req = 2000;
    repeat (8) send_word(acem_pkg::ACT_READ, '0);
  endtask

  // Random phases: new settings, a full frame load, then mostly reads.
  task automatic test_random();
    int sizes [6] = '{0, 1, 64, 127, 2, 5};
    int radii [8] = '{-4096, 4095, -2048, 2048, 0, 1, -2, 3};
    int n;
    while (words_sent < WORD_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        write_reg(acem_pkg::REG_WIDTH, sizes[$urandom_range(0, 5)]);
        write_reg(acem_pkg::REG_HEIGHT,
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : 2);
      end else begin
        write_reg(acem_pkg::REG_WIDTH, $urandom_range(1, 8));
        write_reg(acem_pkg::REG_HEIGHT, $urandom_range(1, 8));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(acem_pkg::REG_RADIUS, radii[$urandom_range(0, 7)]);
      else
        write_reg(acem_pkg::REG_RADIUS, $urandom_range(0, 8191));
      load_frame();
      n = $urandom_range(5, 40);
      repeat (n) begin
        if ($urandom_range(0, 6) == 0) send_word(acem_pkg::ACT_LOAD, rand_pixel());
        else send_word(acem_pkg::ACT_READ, rand_pixel());
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver: random stalls per word, plus a long hold when requested.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Result checker: each accepted word against the oldest expected pixel.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      stall_left = quiet ? 0 : $urandom_range(0, 6);
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output word at cycle %0d", cycles);
      end else begin
        e = pending_words.pop_front();
        if (out_ch.red_out !== e.px.red || out_ch.green_out !== e.px.green ||
            out_ch.blue_out !== e.px.blue || out_ch.alpha_out !== e.px.alpha ||
            out_ch.last_pixel !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at cycle %0d: expected %h %h %h %h last %b, got %h %h %h %h last %b",
                     cycles, e.px.red, e.px.green, e.px.blue, e.px.alpha, e.last,
                     out_ch.red_out, out_ch.green_out, out_ch.blue_out, out_ch.alpha_out,
                     out_ch.last_pixel);
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = acem_pkg::ACT_LOAD;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    in_ch.alpha_in = '0;
    out_ch.ready = 1'b0;
    load_pos = 0;
    read_pos = 0;
    radius_reg = '0;
    width_reg = acem_pkg::DIM_RESET;
    height_reg = acem_pkg::DIM_RESET;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
